@@ hdl/curtain_motor_limit_controller_assert.svh @@
// Assertion macros for the curtain motor limit controller checker.
// Used by hdl/cmlc_checker.sv; needs nothing else.
`ifndef CURTAIN_MOTOR_LIMIT_CONTROLLER_ASSERT_SVH
`define CURTAIN_MOTOR_LIMIT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMLC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmlc assertion failed");

// Next-cycle implication, disabled during reset.
`define CMLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmlc assertion failed");

`endif

@@ hdl/cmlc_pkg.sv @@
// Shared codes and types of the curtain motor limit controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmlc_pkg;

  // Command codes of the mode field.
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_OPEN  = 3'd1;
  localparam logic [2:0] MODE_CLOSE = 3'd2;
  localparam logic [2:0] MODE_STOP  = 3'd3;

  // Reply codes.
  localparam logic [2:0] REPLY_NONE           = 3'd0;
  localparam logic [2:0] REPLY_OPENING        = 3'd1;
  localparam logic [2:0] REPLY_ALREADY_OPEN   = 3'd2;
  localparam logic [2:0] REPLY_CLOSING        = 3'd3;
  localparam logic [2:0] REPLY_ALREADY_CLOSED = 3'd4;
  localparam logic [2:0] REPLY_STOPPING       = 3'd5;
  localparam logic [2:0] REPLY_UNKNOWN        = 3'd6;

  // Limit event codes.
  localparam logic [1:0] EVENT_NONE   = 2'd0;
  localparam logic [1:0] EVENT_OPEN   = 2'd1;
  localparam logic [1:0] EVENT_CLOSED = 2'd2;

  // Debounce threshold after reset.
  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

  // Controller state carried from one pass to the next.
  typedef struct packed {
    logic       moving_open;
    logic       moving_close;
    logic       end_open_flag;
    logic       end_closed_flag;
    logic [7:0] open_hold_count;
    logic [7:0] close_hold_count;
    logic       open_fired;
    logic       close_fired;
  } ctrl_state_t;

  // One result word.
  typedef struct packed {
    logic       drive_open;
    logic       drive_close;
    logic [2:0] reply_code;
    logic [1:0] limit_event;
    logic       at_open_end;
    logic       at_closed_end;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/cmlc_step.sv @@
// Next-state and result logic for one pass of the curtain control loop.
// Purely combinational; depends on cmlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmlc_step
  import cmlc_pkg::*;
(
  input  wire ctrl_state_t state,
  input  wire logic [7:0]  debounce_passes,
  input  wire logic [2:0]  mode,
  input  wire logic        open_limit_low,
  input  wire logic        close_limit_low,
  output ctrl_state_t      state_next,
  output result_t          result
);

  logic [2:0]  reply;
  logic [1:0]  event_code;
  ctrl_state_t s;

  always_comb begin
    s          = state;
    reply      = REPLY_NONE;
    event_code = EVENT_NONE;

    // The command is handled first.
    unique case (mode)
      MODE_NONE: begin
        reply = REPLY_NONE;
      end
      MODE_OPEN: begin
        if (!s.end_open_flag) begin
          s.moving_open  = 1'b1;
          s.moving_close = 1'b0;
          reply          = REPLY_OPENING;
        end else begin
          reply = REPLY_ALREADY_OPEN;
        end
      end
      MODE_CLOSE: begin
        if (!s.end_closed_flag) begin
          s.moving_close = 1'b1;
          s.moving_open  = 1'b0;
          reply          = REPLY_CLOSING;
        end else begin
          reply = REPLY_ALREADY_CLOSED;
        end
      end
      MODE_STOP: begin
        s.moving_open  = 1'b0;
        s.moving_close = 1'b0;
        reply          = REPLY_STOPPING;
      end
      default: begin
        reply = REPLY_UNKNOWN;
      end
    endcase

    // Open-end switch, counted while the motor runs toward it.
    if (!open_limit_low && s.moving_open) begin
      if (s.open_hold_count < debounce_passes) begin
        s.open_hold_count = s.open_hold_count + 8'd1;
      end else if (!s.open_fired) begin
        s.moving_open     = 1'b0;
        s.moving_close    = 1'b0;
        s.open_fired      = 1'b1;
        s.end_open_flag   = 1'b1;
        s.end_closed_flag = 1'b0;
        event_code        = EVENT_OPEN;
      end
    end else begin
      s.open_hold_count = 8'd0;
      s.open_fired      = 1'b0;
    end

    // Closed-end switch, checked after the open end.
    if (!close_limit_low && s.moving_close) begin
      if (s.close_hold_count < debounce_passes) begin
        s.close_hold_count = s.close_hold_count + 8'd1;
      end else if (!s.close_fired) begin
        s.moving_open     = 1'b0;
        s.moving_close    = 1'b0;
        s.close_fired     = 1'b1;
        s.end_open_flag   = 1'b0;
        s.end_closed_flag = 1'b1;
        event_code        = EVENT_CLOSED;
      end
    end else begin
      s.close_hold_count = 8'd0;
      s.close_fired      = 1'b0;
    end
  end

  // Result word reflects the state after the pass.
  assign state_next           = s;
  assign result.drive_open    = s.moving_open;
  assign result.drive_close   = s.moving_close;
  assign result.reply_code    = reply;
  assign result.limit_event   = event_code;
  assign result.at_open_end   = s.end_open_flag;
  assign result.at_closed_end = s.end_closed_flag;

endmodule

`default_nettype wire

@@ hdl/curtain_motor_limit_controller.sv @@
// Top level of the curtain motor limit controller: input register, state,
// result register and threshold register. Depends on cmlc_pkg and cmlc_step.
//
//   Channel  Handshake                 Payload
//   in       in_valid / in_ready       mode, open_limit_low, close_limit_low
//   out      out_valid / out_ready     drive_open, drive_close, reply_code,
//                                      limit_event, at_open_end, at_closed_end
//   cfg      cfg_we                    cfg_wdata (debounce_passes)
//
// One word per cycle is sustained while the output does not stall; a word is
// held in the input register when accepted, then its result is registered.
// The controller state is updated in the same cycle the result is registered,
// so the next word already sees it.
// A stalled output holds its result; the input register keeps one more word.
// Synchronous reset clears state, valids and sets debounce_passes to 20.
`timescale 1ns / 1ps
`default_nettype none

module curtain_motor_limit_controller
  import cmlc_pkg::*;
(
  input  wire  logic       clk,
  input  wire  logic       rst,
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  logic [2:0] mode,
  input  wire  logic       open_limit_low,
  input  wire  logic       close_limit_low,
  output logic             out_valid,
  input  wire  logic       out_ready,
  output logic             drive_open,
  output logic             drive_close,
  output logic [2:0]       reply_code,
  output logic [1:0]       limit_event,
  output logic             at_open_end,
  output logic             at_closed_end,
  input  wire  logic       cfg_we,
  input  wire  logic [7:0] cfg_wdata
);

  logic        in_reg_valid;
  logic [2:0]  in_mode;
  logic        in_open_low;
  logic        in_close_low;
  logic [7:0]  debounce_passes;
  ctrl_state_t state;
  ctrl_state_t state_next;
  result_t     result_next;
  result_t     result;
  logic        advance;

  // The held word moves to the result register when that register is free.
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_passes <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_passes <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode      <= mode;
      in_open_low  <= open_limit_low;
      in_close_low <= close_limit_low;
    end
  end

  // One pass of the control loop.
  cmlc_step u_step (
    .state           (state),
    .debounce_passes (debounce_passes),
    .mode            (in_mode),
    .open_limit_low  (in_open_low),
    .close_limit_low (in_close_low),
    .state_next      (state_next),
    .result          (result_next)
  );

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign drive_open    = result.drive_open;
  assign drive_close   = result.drive_close;
  assign reply_code    = result.reply_code;
  assign limit_event   = result.limit_event;
  assign at_open_end   = result.at_open_end;
  assign at_closed_end = result.at_closed_end;

endmodule

`default_nettype wire

@@ hdl/cmlc_checker.sv @@
// Port-level checker for the curtain motor limit controller, bound to the top.
// Depends on cmlc_pkg and curtain_motor_limit_controller_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "curtain_motor_limit_controller_assert.svh"

module cmlc_checker
  import cmlc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       drive_open,
  input wire logic       drive_close,
  input wire logic [2:0] reply_code,
  input wire logic [1:0] limit_event,
  input wire logic       at_open_end,
  input wire logic       at_closed_end
);

  // A stalled result word stays put.
  `CMLC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({drive_open, drive_close, reply_code, limit_event, at_open_end, at_closed_end}))

  // The motor is never driven both ways.
  `CMLC_ASSERT_IMP(a_drive_excl, clk, rst, out_valid, !(drive_open && drive_close))

  // Reaching the open end stops the motor and marks that end.
  `CMLC_ASSERT_IMP(a_open_event, clk, rst, out_valid && (limit_event == EVENT_OPEN), at_open_end && !at_closed_end && !drive_open && !drive_close)

  // The curtain is never at both ends.
  `CMLC_ASSERT_IMP(a_end_excl, clk, rst, out_valid, !(at_open_end && at_closed_end))

endmodule

bind curtain_motor_limit_controller cmlc_checker u_cmlc_checker (.*);

`default_nettype wire

@@ dv/cmlc_loop_checker.sv @@
// Checker for the curtain motor limit controller: watches both channels and the
// threshold port, predicts each result word and compares it. Depends on cmlc_pkg.
`timescale 1ns / 1ps

module cmlc_loop_checker
  import cmlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] mode,
  input  logic       open_limit_low,
  input  logic       close_limit_low,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       drive_open,
  input  logic       drive_close,
  input  logic [2:0] reply_code,
  input  logic [1:0] limit_event,
  input  logic       at_open_end,
  input  logic       at_closed_end,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         failures,
  output int         outstanding
);

  // Shadow copy of the controller state and its threshold.
  ctrl_state_t loop_state;
  logic [7:0]  hold_threshold;
  result_t     expected_words[$];
  int          errors;

  assign failures = errors;

  // One pass of the control loop: the command first, then the open end, then
  // the closed end, each seeing the motor state left by the step before.
  function automatic result_t step_controller(input logic [2:0] cmd, input logic open_low,
                                              input logic close_low);
    result_t r;
    logic    open_pressed;
    logic    close_pressed;
    r = '0;
    r.reply_code = REPLY_NONE;
    r.limit_event = EVENT_NONE;
    open_pressed = !open_low;
    close_pressed = !close_low;
    case (cmd)
      MODE_NONE: begin
      end
      MODE_OPEN: begin
        if (!loop_state.end_open_flag) begin
          if (!loop_state.moving_open) begin
            loop_state.moving_open = 1'b1;
            loop_state.moving_close = 1'b0;
          end
          r.reply_code = REPLY_OPENING;
        end else begin
          r.reply_code = REPLY_ALREADY_OPEN;
        end
      end
      MODE_CLOSE: begin
        if (!loop_state.end_closed_flag) begin
          if (!loop_state.moving_close) begin
            loop_state.moving_close = 1'b1;
            loop_state.moving_open = 1'b0;
          end
          r.reply_code = REPLY_CLOSING;
        end else begin
          r.reply_code = REPLY_ALREADY_CLOSED;
        end
      end
      MODE_STOP: begin
        loop_state.moving_open = 1'b0;
        loop_state.moving_close = 1'b0;
        r.reply_code = REPLY_STOPPING;
      end
      default: begin
        r.reply_code = REPLY_UNKNOWN;
      end
    endcase

    // Open end: count while pressed and moving toward it, fire once.
    if (open_pressed && loop_state.moving_open) begin
      if (loop_state.open_hold_count < hold_threshold) begin
        loop_state.open_hold_count++;
      end else if (!loop_state.open_fired) begin
        loop_state.moving_open = 1'b0;
        loop_state.moving_close = 1'b0;
        loop_state.open_fired = 1'b1;
        loop_state.end_open_flag = 1'b1;
        loop_state.end_closed_flag = 1'b0;
        r.limit_event = EVENT_OPEN;
      end
    end else begin
      loop_state.open_hold_count = '0;
      loop_state.open_fired = 1'b0;
    end

    // Closed end, same rule.
    if (close_pressed && loop_state.moving_close) begin
      if (loop_state.close_hold_count < hold_threshold) begin
        loop_state.close_hold_count++;
      end else if (!loop_state.close_fired) begin
        loop_state.moving_open = 1'b0;
        loop_state.moving_close = 1'b0;
        loop_state.close_fired = 1'b1;
        loop_state.end_open_flag = 1'b0;
        loop_state.end_closed_flag = 1'b1;
        r.limit_event = EVENT_CLOSED;
      end
    end else begin
      loop_state.close_hold_count = '0;
      loop_state.close_fired = 1'b0;
    end

    r.drive_open = loop_state.moving_open;
    r.drive_close = loop_state.moving_close;
    r.at_open_end = loop_state.end_open_flag;
    r.at_closed_end = loop_state.end_closed_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Sample at the rising edge: compare the leaving word before queuing the new one.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      loop_state = '0;
      hold_threshold = DEBOUNCE_RESET;
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        hold_threshold = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with nothing expected");
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("drive_open", want.drive_open, drive_open);
          check_field("drive_close", want.drive_close, drive_close);
          check_field("reply_code", want.reply_code, reply_code);
          check_field("limit_event", want.limit_event, limit_event);
          check_field("at_open_end", want.at_open_end, at_open_end);
          check_field("at_closed_end", want.at_closed_end, at_closed_end);
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(step_controller(mode, open_limit_low, close_limit_low));
      end
    end
    outstanding = expected_words.size();
  end

endmodule

@@ dv/curtain_motor_limit_controller_test.sv @@
// Top of the curtain motor limit controller test: clock, reset, stimulus and
// verdict. Depends on cmlc_pkg, the controller and dv/cmlc_loop_checker.sv.
`timescale 1ns / 1ps

module curtain_motor_limit_controller_test;
  import cmlc_pkg::*;

  localparam logic [2:0] MODE_UNKNOWN = 3'd4;
  localparam logic       PRESSED = 1'b0;
  localparam logic       RELEASED = 1'b1;
  localparam int         IDLE_PCT = 38;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         RANDOM_WORDS = 1800;
  localparam int         PHASES = 6;
  localparam int         STALL_AFTER = 500;
  localparam int         STALL_CYCLES = 120;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] mode;
  logic       open_limit_low;
  logic       close_limit_low;
  logic       out_valid;
  logic       out_ready;
  logic       drive_open;
  logic       drive_close;
  logic [2:0] reply_code;
  logic [1:0] limit_event;
  logic       at_open_end;
  logic       at_closed_end;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int words_sent;
  bit calm;
  int threshold;
  bit last_toward_open;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  curtain_motor_limit_controller uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .open_limit_low  (open_limit_low),
    .close_limit_low (close_limit_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_open      (drive_open),
    .drive_close     (drive_close),
    .reply_code      (reply_code),
    .limit_event     (limit_event),
    .at_open_end     (at_open_end),
    .at_closed_end   (at_closed_end),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  cmlc_loop_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .open_limit_low  (open_limit_low),
    .close_limit_low (close_limit_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_open      (drive_open),
    .drive_close     (drive_close),
    .reply_code      (reply_code),
    .limit_event     (limit_event),
    .at_open_end     (at_open_end),
    .at_closed_end   (at_closed_end),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .failures        (fail_count),
    .outstanding     (outstanding)
  );

  // Offer one word at the falling edge, with random idle cycles before it,
  // and return at the rising edge that accepts it.
  task automatic send_word(input logic [2:0] cmd, input logic open_low, input logic close_low);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= cmd;
    open_limit_low <= open_low;
    close_limit_low <= close_low;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value[7:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = value;
  endtask

  // A well-formed run: a command toward one end, some travel, then the switch
  // of that end held for about the threshold, with rare bounces and commands.
  task automatic travel_episode;
    bit         toward_open;
    int         travel;
    int         hold;
    logic [2:0] cmd;
    logic       target_low;
    logic       other_low;
    toward_open = ($urandom_range(0, 4) == 0) ? last_toward_open : !last_toward_open;
    last_toward_open = toward_open;
    travel = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) begin
      hold = $urandom_range(0, threshold);
    end else begin
      hold = threshold + $urandom_range(1, 4);
    end
    for (int i = 0; i <= travel + hold; i++) begin
      cmd = MODE_NONE;
      if (i == 0) begin
        cmd = toward_open ? MODE_OPEN : MODE_CLOSE;
      end else if ($urandom_range(0, 29) == 0) begin
        cmd = 3'($urandom_range(0, 7));
      end
      target_low = (i > travel) ? PRESSED : RELEASED;
      other_low = ($urandom_range(0, 19) == 0) ? PRESSED : RELEASED;
      if (toward_open) begin
        send_word(cmd, target_low, other_low);
      end else begin
        send_word(cmd, other_low, target_low);
      end
    end
  endtask

  // Short burst of fully random words.
  task automatic noise_burst;
    int count;
    count = $urandom_range(1, 8);
    repeat (count) begin
      send_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random stalls, one long hold-off, and a calm stretch.
  initial begin
    int taken;
    int stall_left;
    bit stalled_once;
    taken = 0;
    stall_left = 0;
    stalled_once = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        taken++;
        if (taken >= STALL_AFTER && !stalled_once) begin
          stalled_once = 1'b1;
          stall_left = STALL_CYCLES;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int phase_start;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_NONE;
    open_limit_low = RELEASED;
    close_limit_low = RELEASED;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    words_sent = 0;
    calm = 1'b0;
    threshold = int'(DEBOUNCE_RESET);
    last_toward_open = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Every command, unknown codes, and repeated open and close.
    send_word(MODE_NONE, RELEASED, RELEASED);
    for (int m = MODE_UNKNOWN; m < 8; m++) send_word(3'(m), RELEASED, RELEASED);
    send_word(MODE_STOP, RELEASED, RELEASED);
    send_word(MODE_OPEN, RELEASED, RELEASED);
    send_word(MODE_OPEN, RELEASED, RELEASED);
    send_word(MODE_CLOSE, RELEASED, RELEASED);
    send_word(MODE_CLOSE, RELEASED, RELEASED);
    send_word(MODE_STOP, RELEASED, RELEASED);

    // Zero threshold: a command and its limit in one pass, then the refusals.
    write_threshold(0);
    send_word(MODE_OPEN, PRESSED, RELEASED);
    send_word(MODE_OPEN, RELEASED, RELEASED);
    send_word(MODE_CLOSE, RELEASED, PRESSED);
    send_word(MODE_CLOSE, RELEASED, RELEASED);

    // Build up a count under the highest threshold, then lower it below the count.
    write_threshold(255);
    send_word(MODE_OPEN, PRESSED, RELEASED);
    repeat (5) send_word(MODE_NONE, PRESSED, RELEASED);
    write_threshold(2);
    send_word(MODE_NONE, PRESSED, RELEASED);

    // Random phases, each under its own threshold; one phase runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_threshold(int'(DEBOUNCE_RESET));
        1: write_threshold(255);
        2: write_threshold(0);
        3: write_threshold(1);
        4: write_threshold($urandom_range(2, 12));
        default: write_threshold(5);
      endcase
      calm = (p == 3);
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
        if ($urandom_range(0, 3) == 0) begin
          noise_burst();
        end else begin
          travel_episode();
        end
      end
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cmlc_pkg.sv
hdl/cmlc_step.sv
hdl/curtain_motor_limit_controller.sv
hdl/cmlc_checker.sv
dv/cmlc_loop_checker.sv
dv/curtain_motor_limit_controller_test.sv
